// ----- rtl/cfe_pkg.sv -----
// shared types and constants for the command frame encoder
package cfe_pkg;

  // command kinds as carried in the mode field
  typedef enum logic [1:0] {
    MODE_READ     = 2'd0,
    MODE_WRITE    = 2'd1,
    MODE_EXIT_IRQ = 2'd2,
    MODE_ASK_IRQ  = 2'd3
  } cmd_mode_e;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_READ_OPCODE     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_WRITE_OPCODE    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_EXIT_IRQ_OPCODE = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ASK_IRQ_OPCODE  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_XOR_KEY         = 3'd4;

  // register reset values
  localparam logic [7:0]  RST_READ_OPCODE     = 8'h00;
  localparam logic [7:0]  RST_WRITE_OPCODE    = 8'h01;
  localparam logic [7:0]  RST_EXIT_IRQ_OPCODE = 8'h02;
  localparam logic [7:0]  RST_ASK_IRQ_OPCODE  = 8'h03;
  localparam logic [31:0] RST_XOR_KEY         = 32'hCAFE_BABE;

  // length byte per frame kind: body length plus one, also the checksum position
  localparam logic [7:0] LEN_READ  = 8'd7;
  localparam logic [7:0] LEN_WRITE = 8'd11;
  localparam logic [7:0] LEN_IRQ   = 8'd2;

  // byte positions inside a frame
  localparam int unsigned ByteIdxW = 4;
  localparam logic [ByteIdxW-1:0] POS_LEN    = 4'd0;
  localparam logic [ByteIdxW-1:0] POS_OPCODE = 4'd1;
  localparam logic [ByteIdxW-1:0] POS_SIZE   = 4'd2;
  localparam logic [ByteIdxW-1:0] POS_ADDR3  = 4'd3;
  localparam logic [ByteIdxW-1:0] POS_ADDR2  = 4'd4;
  localparam logic [ByteIdxW-1:0] POS_ADDR1  = 4'd5;
  localparam logic [ByteIdxW-1:0] POS_ADDR0  = 4'd6;
  localparam logic [ByteIdxW-1:0] POS_VAL3   = 4'd7;
  localparam logic [ByteIdxW-1:0] POS_VAL2   = 4'd8;
  localparam logic [ByteIdxW-1:0] POS_VAL1   = 4'd9;
  localparam logic [ByteIdxW-1:0] POS_VAL0   = 4'd10;

  // command queue depth
  localparam int unsigned QueueDepth = 2;

  // classified command handed from front to back
  typedef struct packed {
    logic [7:0]  len;
    logic [7:0]  opcode;
    logic [7:0]  size;
    logic [31:0] addr_x;
    logic [31:0] val_x;
  } cmd_t;

endpackage

// ----- rtl/command_frame_encoder.sv -----
// top level of the command frame encoder
// Each accepted command leaves as a frame of 3 (either interrupt), 8 (read) or
// 12 (write) bytes, one byte per cycle on the output stream while the receiver
// does not stall it. The byte serializer in the back end sets that rate. The
// front end classifies a command in the cycle it is taken and parks it in a
// two-entry command queue, so the input keeps accepting while a frame is still
// going out and stalls only when both queue entries are taken. The first byte
// of a frame passes through the command queue and then the back end's output
// register before it leaves. The configuration channel is always ready; write
// it only while the block is idle.
module command_frame_encoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [cfe_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                 cfg_data_i,
  // command input
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // mode[1:0], access_size[9:2], target_address[41:10], write_value[73:42], zero pad
  input  logic [79:0]                 s_axis_tdata_i,
  // frame byte output
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // frame_byte[7:0]
  output logic [7:0]                  m_axis_tdata_o,
  output logic                        m_axis_tlast_o
);
  import cfe_pkg::*;

  logic q_push, q_full, q_pop, q_valid;
  cmd_t push_cmd, head_cmd;

  // accept and classify
  cfe_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (push_cmd)
  );

  // decoupling queue
  cfe_cmd_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  // serialize
  cfe_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i (q_valid),
    .q_cmd_i   (head_cmd),
    .q_pop_o   (q_pop),
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tlast_o
  );

endmodule

// ----- rtl/cfe_front.sv -----
// front end: configuration registers, command accept and classification
module cfe_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [cfe_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [79:0]                  s_axis_tdata_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output cfe_pkg::cmd_t                q_cmd_o
);
  import cfe_pkg::*;

  logic [7:0]  read_op_q, write_op_q, exit_op_q, ask_op_q;
  logic [31:0] key_q;
  cmd_mode_e   mode;
  logic [7:0]  size;
  logic [31:0] addr, val;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_op_q  <= RST_READ_OPCODE;
      write_op_q <= RST_WRITE_OPCODE;
      exit_op_q  <= RST_EXIT_IRQ_OPCODE;
      ask_op_q   <= RST_ASK_IRQ_OPCODE;
      key_q      <= RST_XOR_KEY;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_READ_OPCODE:     read_op_q  <= cfg_data_i[7:0];
        REG_WRITE_OPCODE:    write_op_q <= cfg_data_i[7:0];
        REG_EXIT_IRQ_OPCODE: exit_op_q  <= cfg_data_i[7:0];
        REG_ASK_IRQ_OPCODE:  ask_op_q   <= cfg_data_i[7:0];
        REG_XOR_KEY:         key_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // unpack the input transaction
  assign mode = cmd_mode_e'(s_axis_tdata_i[1:0]);
  assign size = s_axis_tdata_i[9:2];
  assign addr = s_axis_tdata_i[41:10];
  assign val  = s_axis_tdata_i[73:42];

  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;

  // classify: pick opcode and frame length, scramble address and value
  always_comb begin
    q_cmd_o.size   = size;
    q_cmd_o.addr_x = addr ^ key_q;
    q_cmd_o.val_x  = val ^ key_q;
    case (mode)
      MODE_READ: begin
        q_cmd_o.len    = LEN_READ;
        q_cmd_o.opcode = read_op_q;
      end
      MODE_WRITE: begin
        q_cmd_o.len    = LEN_WRITE;
        q_cmd_o.opcode = write_op_q;
      end
      MODE_EXIT_IRQ: begin
        q_cmd_o.len    = LEN_IRQ;
        q_cmd_o.opcode = exit_op_q;
      end
      default: begin
        q_cmd_o.len    = LEN_IRQ;
        q_cmd_o.opcode = ask_op_q;
      end
    endcase
  end

endmodule

// ----- rtl/cfe_cmd_queue.sv -----
// short command queue between front and back
module cfe_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cfe_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output cfe_pkg::cmd_t cmd_o
);
  import cfe_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/cfe_back.sv -----
// back end: serializes one queued command into frame bytes with running checksum
module cfe_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  cfe_pkg::cmd_t q_cmd_i,
  output logic          q_pop_o,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [7:0]    m_axis_tdata_o,
  output logic          m_axis_tlast_o
);
  import cfe_pkg::*;

  logic [ByteIdxW-1:0] idx_q, idx_d;
  logic [7:0]          sum_q, sum_d;
  logic                out_vld_q, out_vld_d;
  logic [7:0]          out_data_q, out_data_d;
  logic                out_last_q, out_last_d;
  logic                advance, is_last;
  logic [7:0]          cur_byte;

  assign advance = q_valid_i && (!out_vld_q || m_axis_tready_i);
  assign is_last = ({4'd0, idx_q} == q_cmd_i.len);
  assign q_pop_o = advance && is_last;

  // byte at the current position; the checksum closes the frame
  always_comb begin
    if (is_last) begin
      cur_byte = 8'd0 - sum_q;
    end else begin
      case (idx_q)
        POS_LEN:    cur_byte = q_cmd_i.len;
        POS_OPCODE: cur_byte = q_cmd_i.opcode;
        POS_SIZE:   cur_byte = q_cmd_i.size;
        POS_ADDR3:  cur_byte = q_cmd_i.addr_x[31:24];
        POS_ADDR2:  cur_byte = q_cmd_i.addr_x[23:16];
        POS_ADDR1:  cur_byte = q_cmd_i.addr_x[15:8];
        POS_ADDR0:  cur_byte = q_cmd_i.addr_x[7:0];
        POS_VAL3:   cur_byte = q_cmd_i.val_x[31:24];
        POS_VAL2:   cur_byte = q_cmd_i.val_x[23:16];
        POS_VAL1:   cur_byte = q_cmd_i.val_x[15:8];
        POS_VAL0:   cur_byte = q_cmd_i.val_x[7:0];
        default:    cur_byte = 8'd0;
      endcase
    end
  end

  // position, checksum and output register updates
  always_comb begin
    idx_d      = idx_q;
    sum_d      = sum_q;
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    out_last_d = out_last_q;
    if (advance) begin
      out_vld_d  = 1'b1;
      out_data_d = cur_byte;
      out_last_d = is_last;
      if (is_last) begin
        idx_d = POS_LEN;
        sum_d = 8'd0;
      end else begin
        idx_d = idx_q + 1'b1;
        sum_d = sum_q + cur_byte;
      end
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= POS_LEN;
      sum_q     <= 8'd0;
      out_vld_q <= 1'b0;
    end else begin
      idx_q     <= idx_d;
      sum_q     <= sum_d;
      out_vld_q <= out_vld_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ----- rtl/cfe_checker.sv -----
// port-level checks on the frame output stream, bound to the top level
module cfe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o
);
  logic       out_xfer;
  logic [3:0] pos_q;

  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;

  // byte position within the current frame, as seen on the port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 4'd0;
    end else if (out_xfer) begin
      if (m_axis_tlast_o || pos_q == 4'd15) begin
        pos_q <= 4'd0;
      end else begin
        pos_q <= pos_q + 4'd1;
      end
    end
  end

  // stalled output holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output changed while stalled");

  // first byte of a frame is a legal length byte
  a_len_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && pos_q == 4'd0 |->
      m_axis_tdata_o == 8'd2 || m_axis_tdata_o == 8'd7 || m_axis_tdata_o == 8'd11)
    else $error("bad length byte");

  // tlast lands only where a frame can end
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |->
      pos_q == 4'd2 || pos_q == 4'd7 || pos_q == 4'd11)
    else $error("tlast at wrong position");

  // no frame runs past twelve bytes
  a_max_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> pos_q <= 4'd11)
    else $error("frame too long");

endmodule

bind command_frame_encoder cfe_checker u_checker (.*);
